// ----- hw/rtl/ltpt_pkg.sv -----
`timescale 1ns / 1ps

package ltpt_pkg;

    // Configuration register map, word index = paddr / 4
    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_DEADBAND = 2'd2
    } cfg_reg_t;

    localparam int CFG_ADDR_BITS  = 4;
    localparam int CFG_DATA_BITS  = 32;

    localparam int CENTER_X_RESET = 320;
    localparam int CENTER_Y_RESET = 240;
    localparam int DEADBAND_RESET = 250;

endpackage

// ----- hw/rtl/ltpt_axis_step.sv -----
`timescale 1ns / 1ps

module ltpt_axis_step #(
    parameter int COORD_BITS = 12,
    parameter int ANGLE_BITS = 16
) (
    input  logic                         step_en,
    input  logic [COORD_BITS-1:0]        mid,
    input  logic [COORD_BITS:0]          pos,
    input  logic [COORD_BITS-1:0]        deadband,
    input  logic signed [ANGLE_BITS-1:0] angle,
    output logic                         moved,
    output logic signed [ANGLE_BITS-1:0] angle_next
);

    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};
    localparam logic [ANGLE_BITS-1:0] ANGLE_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    logic [COORD_BITS:0] mid_ext;
    logic                right_of;
    logic [COORD_BITS:0] mag;
    logic                exceed;

    assign mid_ext  = {1'b0, mid};
    assign right_of = (mid_ext < pos);
    assign mag      = right_of ? (pos - mid_ext) : (mid_ext - pos);
    assign exceed   = (mag > {1'b0, deadband});
    assign moved    = step_en && exceed;

    // Step away from the side the target lies on, hold at the rails
    always_comb begin
        angle_next = angle;
        if (moved) begin
            if (right_of) begin
                if (angle != ANGLE_MIN) begin
                    angle_next = angle - ANGLE_BITS'(1);
                end
            end else begin
                if (angle != ANGLE_MAX) begin
                    angle_next = angle + ANGLE_BITS'(1);
                end
            end
        end
    end

endmodule

// ----- hw/rtl/largest_target_pan_tilt_tracker_core.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Ports                    Word contents (low bit first)
// s_        in   tvalid/tready/tdata      rect_x, rect_y, rect_width, rect_height
//                tlast, tuser             tlast = last_in_frame, tuser = no_rectangle
// m_        out  tvalid/tready/tdata      pan_position, tilt_position, pan_moved,
//                                         tilt_moved, target_found, target_center_x,
//                                         target_center_y
// APB       in   psel/penable/pwrite/...  center_x @0x0, center_y @0x4, deadband @0x8
//
// One input word per cycle while the input is not stalled. Rectangle area and centre are
// formed on the way into the input register; the area compare, best-rectangle update and
// axis stepping sit between the input register and the result register, so a frame result
// is loaded into the result register as its closing word leaves the input register.
// Reset (aresetn low, synchronous) clears the pipeline valids, the tracking state and
// the angles, and loads the configuration reset values.
// A stalled result holds the next frame's closing word in the input register, which
// then stalls the input; other words keep flowing through the input register.

module largest_target_pan_tilt_tracker_core #(
    parameter int COORD_BITS = 12,
    parameter int ANGLE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // rect_x, rect_y, rect_width, rect_height, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    input  logic                                 s_tlast,
    // no_rectangle
    input  logic                                 s_tuser,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pan_position, tilt_position, pan_moved, tilt_moved, target_found,
    // target_center_x, target_center_y, zero pad
    output logic [((2*ANGLE_BITS+3+2*(COORD_BITS+1)+7)/8)*8-1:0] m_tdata,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ltpt_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [ltpt_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [ltpt_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    localparam int AREA_BITS   = 2*COORD_BITS;
    localparam int CTR_BITS    = COORD_BITS + 1;
    localparam int M_FIELDS    = 2*ANGLE_BITS + 3 + 2*CTR_BITS;
    localparam int M_DATA_BITS = ((M_FIELDS+7)/8)*8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] center_x_reg;
    logic [COORD_BITS-1:0] center_y_reg;
    logic [COORD_BITS-1:0] deadband_reg;
    logic                  cfg_wr;
    ltpt_pkg::cfg_reg_t    cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = ltpt_pkg::cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= COORD_BITS'(ltpt_pkg::CENTER_X_RESET);
            center_y_reg <= COORD_BITS'(ltpt_pkg::CENTER_Y_RESET);
            deadband_reg <= COORD_BITS'(ltpt_pkg::DEADBAND_RESET);
        end else if (cfg_wr) begin
            case (cfg_sel)
                ltpt_pkg::REG_CENTER_X: center_x_reg <= pwdata[COORD_BITS-1:0];
                ltpt_pkg::REG_CENTER_Y: center_y_reg <= pwdata[COORD_BITS-1:0];
                ltpt_pkg::REG_DEADBAND: deadband_reg <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            ltpt_pkg::REG_CENTER_X: prdata = ltpt_pkg::CFG_DATA_BITS'(center_x_reg);
            ltpt_pkg::REG_CENTER_Y: prdata = ltpt_pkg::CFG_DATA_BITS'(center_y_reg);
            ltpt_pkg::REG_DEADBAND: prdata = ltpt_pkg::CFG_DATA_BITS'(deadband_reg);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register: area and centre of the incoming rectangle
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] in_x, in_y, in_w, in_h;
    logic [AREA_BITS-1:0]  in_area;
    logic [CTR_BITS-1:0]   in_cx, in_cy;

    assign in_x    = s_tdata[COORD_BITS-1:0];
    assign in_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_w    = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_h    = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign in_area = {{COORD_BITS{1'b0}}, in_w} * {{COORD_BITS{1'b0}}, in_h};
    assign in_cx   = {1'b0, in_x} + {2'b00, in_w[COORD_BITS-1:1]};
    assign in_cy   = {1'b0, in_y} + {2'b00, in_h[COORD_BITS-1:1]};

    logic                 s1_vld_reg;
    logic [AREA_BITS-1:0] s1_area_reg;
    logic [CTR_BITS-1:0]  s1_cx_reg, s1_cy_reg;
    logic                 s1_last_reg, s1_none_reg;
    logic                 s1_end, s1_go, out_free, s_take;

    assign s1_end   = s1_last_reg || s1_none_reg;
    assign out_free = !m_tvalid || m_tready;
    // A frame-closing word needs a free result slot; others always advance
    assign s1_go    = s1_vld_reg && (!s1_end || out_free);
    assign s_tready = !s1_vld_reg || s1_go;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s_tready) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            s1_area_reg <= in_area;
            s1_cx_reg   <= in_cx;
            s1_cy_reg   <= in_cy;
            s1_last_reg <= s_tlast;
            s1_none_reg <= s_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Best-rectangle tracking and frame-end stepping
    // ------------------------------------------------------------------
    logic                         have_best_reg, have_best_next;
    logic [AREA_BITS-1:0]         best_area_reg, best_area_next;
    logic [CTR_BITS-1:0]          best_cx_reg, best_cx_next;
    logic [CTR_BITS-1:0]          best_cy_reg, best_cy_next;
    logic signed [ANGLE_BITS-1:0] pan_reg, pan_next;
    logic signed [ANGLE_BITS-1:0] tilt_reg, tilt_next;

    logic                         take_rect, eff_have, out_load;
    logic [CTR_BITS-1:0]          eff_cx, eff_cy;
    logic                         pan_moved, tilt_moved;
    logic signed [ANGLE_BITS-1:0] pan_step, tilt_step;

    // First rectangle of a frame is always kept; later ones only if strictly larger
    assign take_rect = !s1_none_reg && (!have_best_reg || (s1_area_reg > best_area_reg));
    assign eff_have  = have_best_reg || !s1_none_reg;
    assign eff_cx    = take_rect ? s1_cx_reg : best_cx_reg;
    assign eff_cy    = take_rect ? s1_cy_reg : best_cy_reg;
    assign out_load  = s1_go && s1_end;

    ltpt_axis_step #(
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_pan_step (
        .step_en    (eff_have),
        .mid        (center_x_reg),
        .pos        (eff_cx),
        .deadband   (deadband_reg),
        .angle      (pan_reg),
        .moved      (pan_moved),
        .angle_next (pan_step)
    );

    ltpt_axis_step #(
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_tilt_step (
        .step_en    (eff_have),
        .mid        (center_y_reg),
        .pos        (eff_cy),
        .deadband   (deadband_reg),
        .angle      (tilt_reg),
        .moved      (tilt_moved),
        .angle_next (tilt_step)
    );

    always_comb begin
        have_best_next = have_best_reg;
        best_area_next = best_area_reg;
        best_cx_next   = best_cx_reg;
        best_cy_next   = best_cy_reg;
        pan_next       = pan_reg;
        tilt_next      = tilt_reg;
        if (s1_go) begin
            if (take_rect) begin
                best_area_next = s1_area_reg;
                best_cx_next   = s1_cx_reg;
                best_cy_next   = s1_cy_reg;
            end
            if (s1_end) begin
                // Close the frame: commit the steps and drop the running best
                have_best_next = 1'b0;
                best_area_next = '0;
                pan_next       = pan_step;
                tilt_next      = tilt_step;
            end else begin
                have_best_next = eff_have;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg <= 1'b0;
            best_area_reg <= '0;
            best_cx_reg   <= '0;
            best_cy_reg   <= '0;
            pan_reg       <= '0;
            tilt_reg      <= '0;
        end else begin
            have_best_reg <= have_best_next;
            best_area_reg <= best_area_next;
            best_cx_reg   <= best_cx_next;
            best_cy_reg   <= best_cy_next;
            pan_reg       <= pan_next;
            tilt_reg      <= tilt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                   m_vld_reg;
    logic [M_FIELDS-1:0]    m_fields_reg;
    logic [M_FIELDS-1:0]    res_fields;
    logic [CTR_BITS-1:0]    res_cx, res_cy;

    assign res_cx     = eff_have ? eff_cx : '0;
    assign res_cy     = eff_have ? eff_cy : '0;
    assign res_fields = {res_cy, res_cx, eff_have, tilt_moved, pan_moved,
                         tilt_step, pan_step};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (out_free) begin
            m_vld_reg <= out_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_fields_reg <= res_fields;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = M_DATA_BITS'(m_fields_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A new result only follows a frame-closing word
    a_result_from_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_vld_reg) |-> $past(out_load))
        else $error("result raised without a frame-closing word");

    // Closing a frame always drops the running best
    a_best_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> !have_best_reg && (best_area_reg == '0))
        else $error("running best not cleared at frame end");

    // A frame without a target leaves both angles untouched
    a_no_target_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !eff_have) |=> $stable(pan_reg) && $stable(tilt_reg))
        else $error("angle changed on an empty frame");

    // Move flags never appear on a result without a target
    a_moved_needs_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg |-> m_fields_reg[2*ANGLE_BITS+2] ||
                      (!m_fields_reg[2*ANGLE_BITS] && !m_fields_reg[2*ANGLE_BITS+1]))
        else $error("move flag set without a target");

endmodule

// ----- tb/tb_largest_target_pan_tilt_tracker_core.sv -----
`timescale 1ns / 1ps

module tb_largest_target_pan_tilt_tracker_core;

    localparam int COORD_W   = 12;
    localparam int ANGLE_W   = 16;
    localparam int S_DATA_W  = ((4*COORD_W+7)/8)*8;
    localparam int M_DATA_W  = ((2*ANGLE_W+3+2*(COORD_W+1)+7)/8)*8;
    localparam int ANGLE_TOP = 32767;
    localparam int ANGLE_BOT = -32768;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD   = 400;

    // One detection word as the sender sees it
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic               last;
        logic               none;
    } rect_word_t;

    // One frame result: angles, move flags and the chosen target centre
    typedef struct {
        logic signed [ANGLE_W-1:0] pan;
        logic signed [ANGLE_W-1:0] tilt;
        logic                      pan_moved;
        logic                      tilt_moved;
        logic                      found;
        logic [COORD_W:0]          cx;
        logic [COORD_W:0]          cy;
    } aim_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // rect_x, rect_y, rect_width, rect_height
    logic [S_DATA_W-1:0]               s_tdata = '0;
    logic                              s_tlast = 1'b0;
    // no_rectangle
    logic                              s_tuser = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // pan_position, tilt_position, pan_moved, tilt_moved, target_found,
    // target_center_x, target_center_y, zero pad
    logic [M_DATA_W-1:0]               m_tdata;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [ltpt_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [ltpt_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
    logic [ltpt_pkg::CFG_DATA_BITS-1:0] prdata;
    logic                              pready;

    largest_target_pan_tilt_tracker_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tracker state mirrored on the testbench side
    // ------------------------------------------------------------------
    logic [COORD_W-1:0]   mid_x = COORD_W'(ltpt_pkg::CENTER_X_RESET);
    logic [COORD_W-1:0]   mid_y = COORD_W'(ltpt_pkg::CENTER_Y_RESET);
    logic [COORD_W-1:0]   dead_zone = COORD_W'(ltpt_pkg::DEADBAND_RESET);
    bit                   have_target = 1'b0;
    logic [2*COORD_W-1:0] target_area = '0;
    logic [COORD_W:0]     target_cx = '0;
    logic [COORD_W:0]     target_cy = '0;
    int                   pan_pos = 0;
    int                   tilt_pos = 0;

    rect_word_t rect_words[$];   // words waiting to be sent
    aim_t       aim_q[$];        // frame results still owed by the block

    int  mismatch_count = 0;
    int  words_taken = 0;
    int  frames_checked = 0;
    int  frames_with_target = 0;
    int  cfg_writes = 0;
    int  cycle_count = 0;

    // Step one axis toward the target; report whether the deadband was exceeded
    task automatic step_axis(input int mid, input int pos, inout int angle,
                             output logic moved);
        int offset;
        offset = mid - pos;
        if (offset < 0) offset = -offset;
        moved = 1'b0;
        if (offset > int'(dead_zone)) begin
            moved = 1'b1;
            if (mid < pos) begin
                if (angle > ANGLE_BOT) angle = angle - 1;
            end else begin
                if (angle < ANGLE_TOP) angle = angle + 1;
            end
        end
    endtask

    // Fold one word into the frame; on a frame end, hand back the result
    task automatic track_word(input rect_word_t wd, output bit done, output aim_t res);
        logic [2*COORD_W-1:0] area;
        area = (2*COORD_W)'(wd.w) * (2*COORD_W)'(wd.h);
        done = 1'b0;
        res = '{default: '0};
        if (!wd.none && (!have_target || area > target_area)) begin
            have_target = 1'b1;
            target_area = area;
            target_cx   = {1'b0, wd.x} + {2'b00, wd.w[COORD_W-1:1]};
            target_cy   = {1'b0, wd.y} + {2'b00, wd.h[COORD_W-1:1]};
        end
        if (!wd.last && !wd.none) return;
        done = 1'b1;
        res.found = have_target;
        if (have_target) begin
            res.cx = target_cx;
            res.cy = target_cy;
            step_axis(int'(mid_x), int'(target_cx), pan_pos, res.pan_moved);
            step_axis(int'(mid_y), int'(target_cy), tilt_pos, res.tilt_moved);
        end
        res.pan  = ANGLE_W'(pan_pos);
        res.tilt = ANGLE_W'(tilt_pos);
        have_target = 1'b0;
        target_area = '0;
    endtask

    // ------------------------------------------------------------------
    // Idle-gap picking: mostly short gaps, a few long ones
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Sender: feed words from rect_words, with gaps after each accepted word
    // ------------------------------------------------------------------
    int         tx_gap = 0;
    int         tx_calm = 0;
    rect_word_t tx_word;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
            tx_calm  <= 0;
        end else begin
            // open a stretch without gaps now and then
            if (tx_calm > 0) begin
                tx_calm <= tx_calm - 1;
            end else if ($urandom_range(0, 199) == 0) begin
                tx_calm <= $urandom_range(30, 120);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (rect_words.size() > 0) begin
                    tx_word  = rect_words.pop_front();
                    s_tdata  <= {tx_word.h, tx_word.w, tx_word.y, tx_word.x};
                    s_tlast  <= tx_word.last;
                    s_tuser  <= tx_word.none;
                    s_tvalid <= 1'b1;
                    tx_gap   <= (tx_calm > 0) ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    bit rx_hold_req = 1'b0;
    bit rx_hold_done = 1'b0;
    int rx_hold_left = 0;
    int rx_gap = 0;
    int rx_calm = 0;
    int rx_pick;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
            rx_calm  <= 0;
        end else begin
            if (rx_calm > 0) begin
                rx_calm <= rx_calm - 1;
            end else if ($urandom_range(0, 199) == 0) begin
                rx_calm <= $urandom_range(30, 120);
            end
            if (rx_hold_req && !rx_hold_done) begin
                // hold off long enough for the block to fill and stall its input
                rx_hold_done <= 1'b1;
                rx_hold_left <= LONG_HOLD;
                m_tready     <= 1'b0;
            end else if (rx_hold_left > 0) begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready     <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end else begin
                rx_pick = (rx_calm > 0) ? 0 : pick_gap();
                if (rx_pick > 0) begin
                    rx_gap   <= rx_pick - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input monitor: predict on every accepted word
    // ------------------------------------------------------------------
    rect_word_t seen_word;
    bit         frame_done;
    aim_t       owed;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            seen_word.x    = s_tdata[COORD_W-1:0];
            seen_word.y    = s_tdata[2*COORD_W-1:COORD_W];
            seen_word.w    = s_tdata[3*COORD_W-1:2*COORD_W];
            seen_word.h    = s_tdata[4*COORD_W-1:3*COORD_W];
            seen_word.last = s_tlast;
            seen_word.none = s_tuser;
            words_taken++;
            track_word(seen_word, frame_done, owed);
            if (frame_done) aim_q.push_back(owed);
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: compare every accepted result with the oldest one owed
    // ------------------------------------------------------------------
    aim_t got;
    aim_t want;

    task automatic report_field(input string name, input int exp_v, input int act_v);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.pan        = m_tdata[15:0];
            got.tilt       = m_tdata[31:16];
            got.pan_moved  = m_tdata[32];
            got.tilt_moved = m_tdata[33];
            got.found      = m_tdata[34];
            got.cx         = m_tdata[47:35];
            got.cy         = m_tdata[60:48];
            if (aim_q.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: unexpected result word, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want = aim_q.pop_front();
                frames_checked++;
                if (want.found) frames_with_target++;
                if (got.pan !== want.pan)
                    report_field("pan_position", want.pan, got.pan);
                if (got.tilt !== want.tilt)
                    report_field("tilt_position", want.tilt, got.tilt);
                if (got.pan_moved !== want.pan_moved)
                    report_field("pan_moved", want.pan_moved, got.pan_moved);
                if (got.tilt_moved !== want.tilt_moved)
                    report_field("tilt_moved", want.tilt_moved, got.tilt_moved);
                if (got.found !== want.found)
                    report_field("target_found", want.found, got.found);
                if (got.cx !== want.cx)
                    report_field("target_center_x", want.cx, got.cx);
                if (got.cy !== want.cy)
                    report_field("target_center_y", want.cy, got.cy);
            end
        end
    end

    // Watchdog: end the run if it never finishes
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, aim_q.size());
            $display("tb_largest_target_pan_tilt_tracker_core NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_word(input int x, input int y, input int w, input int h,
                                      input bit last, input bit none);
        rect_word_t wd;
        wd.x = COORD_W'(x);
        wd.y = COORD_W'(y);
        wd.w = COORD_W'(w);
        wd.h = COORD_W'(h);
        wd.last = last;
        wd.none = none;
        rect_words.push_back(wd);
    endfunction

    // APB write: setup cycle, then access cycle; mirror the value once written
    task automatic write_reg(input ltpt_pkg::cfg_reg_t idx, input int value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ltpt_pkg::CFG_ADDR_BITS'(idx) << 2;
        pwdata  <= ltpt_pkg::CFG_DATA_BITS'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ltpt_pkg::REG_CENTER_X: mid_x = COORD_W'(value);
            ltpt_pkg::REG_CENTER_Y: mid_y = COORD_W'(value);
            ltpt_pkg::REG_DEADBAND: dead_zone = COORD_W'(value);
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic write_all(input int cx, input int cy, input int db);
        write_reg(ltpt_pkg::REG_CENTER_X, cx);
        write_reg(ltpt_pkg::REG_CENTER_Y, cy);
        write_reg(ltpt_pkg::REG_DEADBAND, db);
    endtask

    // Wait until every word is sent and every result is back, then let the pipe settle
    task automatic drain();
        while (rect_words.size() != 0 || s_tvalid || aim_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Coordinate with a bias toward the edges and toward small values (area ties)
    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 4095;
        if (r <= 3) return $urandom_range(0, 15);
        return $urandom_range(0, 4095);
    endfunction

    // Queue one random frame; return the number of words it holds
    function automatic int push_frame();
        int r;
        int n;
        bit end_with_marker;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            // frame with no detections
            push_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(0, 1), 1'b1);
            return 1;
        end
        r = $urandom_range(0, 99);
        n = (r < 70) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 10)
                                                        : $urandom_range(11, 30);
        // sometimes cut the frame short with an empty marker
        end_with_marker = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++) begin
            push_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      (i == n-1) && !end_with_marker, 1'b0);
        end
        if (end_with_marker) begin
            push_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(0, 1), 1'b1);
            n++;
        end
        return n;
    endfunction

    task automatic random_phase(input int words);
        int queued;
        queued = 0;
        while (queued < words) queued += push_frame();
        drain();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames under the reset configuration
        push_word(0, 0, 0, 0, 1, 0);                 // zero-area rectangle alone
        push_word(4095, 4095, 4095, 4095, 1, 0);     // every field at its top
        push_word(4095, 4095, 4095, 4095, 0, 1);     // empty marker, last low
        push_word(0, 0, 0, 0, 1, 1);                 // empty marker, last high
        // equal area must not replace the first rectangle
        push_word(10, 10, 10, 10, 0, 0);
        push_word(500, 400, 4, 25, 0, 0);
        push_word(0, 0, 5, 10, 0, 0);
        push_word(600, 0, 9, 11, 1, 0);
        // zero area kept until something strictly larger arrives
        push_word(3000, 3000, 0, 7, 0, 0);
        push_word(0, 0, 1, 1, 1, 0);
        push_word(100, 100, 0, 0, 0, 0);
        push_word(900, 900, 5, 0, 1, 0);
        // offsets exactly at and just past the deadband on both sides for pan, one side for tilt
        push_word(70, 0, 0, 0, 1, 0);
        push_word(69, 0, 0, 0, 1, 0);
        push_word(570, 0, 0, 0, 1, 0);
        push_word(571, 0, 0, 0, 1, 0);
        push_word(320, 490, 0, 0, 1, 0);
        push_word(320, 491, 0, 0, 1, 0);
        // rectangles closed by an empty marker instead of last
        push_word(100, 200, 50, 60, 0, 0);
        push_word(0, 0, 0, 0, 0, 1);
        push_word(7, 8, 2, 3, 1, 0);
        push_word(320, 240, 0, 0, 1, 0);             // target dead on centre
        drain();

        // Walk pan up and tilt down for a stretch of single-word frames
        write_all(4095, 0, 0);
        for (int i = 0; i < 40; i++) push_word(0, 4095, 0, 4095, 1, 0);
        drain();

        // Random frames under several settings
        write_all(0, 4095, 4095);
        random_phase(110);

        write_all($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
        rx_hold_req <= 1'b1;
        random_phase(110);

        write_all($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 300));
        random_phase(110);

        write_all(4095, 4095, 0);
        random_phase(110);

        repeat (16) @(posedge aclk);
        $display("run covered %0d rectangle words and %0d frame results (%0d with a target)",
                 words_taken, frames_checked, frames_with_target);
        $display("with %0d register writes and one long output hold-off", cfg_writes);
        if (mismatch_count == 0 && aim_q.size() == 0) begin
            $display("tb_largest_target_pan_tilt_tracker_core OK");
        end else begin
            $display("tb_largest_target_pan_tilt_tracker_core NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ltpt_pkg.sv
hw/rtl/ltpt_axis_step.sv
hw/rtl/largest_target_pan_tilt_tracker_core.sv
tb/tb_largest_target_pan_tilt_tracker_core.sv
